// ===== sv/stt_pkg.sv =====
`default_nettype none
package stt_pkg;
    localparam int MaxLexeme  = 255;
    localparam int LineBits   = 16;
    localparam int OffsetBits = 20;

    typedef enum logic [2:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_EQ, M_HALT
    } t_mode;

    localparam logic [4:0] K_END    = 5'd0;
    localparam logic [4:0] K_IDENT  = 5'd1;
    localparam logic [4:0] K_NUMBER = 5'd2;
    localparam logic [4:0] K_STRING = 5'd3;
    localparam logic [4:0] K_VAR    = 5'd4;
    localparam logic [4:0] K_IF     = 5'd5;
    localparam logic [4:0] K_PRINT  = 5'd6;
    localparam logic [4:0] K_PARSE  = 5'd7;
    localparam logic [4:0] K_ASSIGN = 5'd8;
    localparam logic [4:0] K_PLUS   = 5'd9;
    localparam logic [4:0] K_MINUS  = 5'd10;
    localparam logic [4:0] K_STAR   = 5'd11;
    localparam logic [4:0] K_SLASH  = 5'd12;
    localparam logic [4:0] K_GT     = 5'd13;
    localparam logic [4:0] K_LT     = 5'd14;
    localparam logic [4:0] K_EQEQ   = 5'd15;
    localparam logic [4:0] K_LPAREN = 5'd16;
    localparam logic [4:0] K_RPAREN = 5'd17;
    localparam logic [4:0] K_LBRACE = 5'd18;
    localparam logic [4:0] K_RBRACE = 5'd19;
    localparam logic [4:0] K_COMMA  = 5'd20;
    localparam logic [4:0] K_ERROR  = 5'd21;

    // Returns 0 when the byte is not a single-byte operator.
    function automatic logic [4:0] single_kind(input logic [7:0] b);
        logic [4:0] k;
        k = K_END;
        case (b)
            "+": k = K_PLUS;
            "-": k = K_MINUS;
            "*": k = K_STAR;
            "/": k = K_SLASH;
            ">": k = K_GT;
            "<": k = K_LT;
            "(": k = K_LPAREN;
            ")": k = K_RPAREN;
            "{": k = K_LBRACE;
            "}": k = K_RBRACE;
            ",": k = K_COMMA;
            default: k = K_END;
        endcase
        return k;
    endfunction

    // Keyword text as a five-byte field, one byte per position (0 beyond the word's end).
    function automatic logic [7:0] kw_char(input logic [1:0] w, input logic [2:0] p);
        logic [39:0] s;
        case (w)
            2'd0: s = {"var", 16'h0};
            2'd1: s = {"if", 24'h0};
            2'd2: s = "print";
            default: s = "parse";
        endcase
        return (p < 3'd5) ? s[8*(4-p) +: 8] : 8'h00;
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] w);
        logic [2:0] l;
        case (w)
            2'd0: l = 3'd3;
            2'd1: l = 3'd2;
            default: l = 3'd5;
        endcase
        return l;
    endfunction

    // One beat of the front part's work, waiting for the token builder.
    typedef struct packed {
        logic       eoi;
        logic [7:0] b;
    } t_item;
endpackage
`default_nettype wire

// ===== sv/stt_front.sv =====
`default_nettype none
// Input stage and a two-entry queue toward the token builder.
module stt_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_stall,
    input  wire              i_kind,
    input  wire [7:0]        i_data_byte,
    output logic             o_q_valid,
    output stt_pkg::t_item   o_q_item,
    input  wire              i_q_take
);
    stt_pkg::t_item r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           push;

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{eoi: i_kind, b: i_data_byte};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_take};
        end
    end
endmodule
`default_nettype wire

// ===== sv/stt_back.sv =====
`default_nettype none
// Token builder: consumes one queued beat per cycle when the result slots are empty or their last token is being taken.
module stt_back #(
    parameter int MAX_LEXEME  = stt_pkg::MaxLexeme,
    parameter int LINE_BITS   = stt_pkg::LineBits,
    parameter int OFFSET_BITS = stt_pkg::OffsetBits
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_q_valid,
    input  stt_pkg::t_item   i_q_item,
    output logic             o_q_take,
    output logic             o_valid,
    input  wire              i_stall,
    output logic [4:0]       o_token_kind,
    output logic [15:0]      o_token_line,
    output logic [15:0]      o_token_column,
    output logic [19:0]      o_start_offset,
    output logic [7:0]       o_lexeme_length,
    output logic             o_truncated,
    output logic             o_last_of_run
);
    localparam int CntBits = $clog2(MAX_LEXEME + 1);
    localparam logic [CntBits-1:0] CntMax = CntBits'(MAX_LEXEME);
    localparam logic [LINE_BITS-1:0] LineTop = '1;
    localparam logic [OFFSET_BITS-1:0] OffTop = '1;
    localparam int TokW = 5 + 16 + 16 + 20 + 8 + 1;

    stt_pkg::t_mode         r_mode, n_mode;
    logic [3:0]             r_cand, n_cand;
    logic [CntBits-1:0]     r_cnt, n_cnt;
    logic                   r_ovf, n_ovf;
    logic [OFFSET_BITS-1:0] r_soff, n_soff, r_off, n_off;
    logic [LINE_BITS-1:0]   r_sline, n_sline, r_scol, n_scol, r_line, n_line;
    logic [LINE_BITS-1:0]   r_col, n_col, col;

    // Output slots: two tokens at most per beat, shifted out one by one.
    logic [TokW-1:0] r_tok [2];
    logic            r_last [2];
    logic [1:0]      r_n;
    logic [TokW-1:0] t0, t1;
    logic [1:0]      nt;
    logic            pop;

    logic [7:0] b;
    logic       is_al, is_dg, is_sp, is_id;

    function automatic logic [TokW-1:0] mk(input logic [4:0] k,
        input logic [LINE_BITS-1:0] l, input logic [LINE_BITS-1:0] c,
        input logic [OFFSET_BITS-1:0] o, input logic [CntBits-1:0] n,
        input logic tr);
        logic [15:0] l16, c16;
        logic [19:0] o20;
        logic [7:0]  n8;
        logic        big;
        l16 = 16'(l);
        c16 = 16'(c);
        o20 = 20'(o);
        big = (32'(n) > 32'd255);
        n8  = big ? 8'hFF : 8'(n);
        return {k, l16, c16, o20, n8, tr | big};
    endfunction

    assign pop = o_valid && !i_stall;
    assign o_valid = (r_n != 2'd0);
    assign {o_token_kind, o_token_line, o_token_column, o_start_offset,
            o_lexeme_length, o_truncated} = r_tok[0];
    assign o_last_of_run = r_last[0];
    // Accept a beat only when the slots will be empty after this cycle.
    assign o_q_take = i_q_valid && (r_n == 2'd0 || (r_n == 2'd1 && pop));

    assign b     = i_q_item.b;
    assign is_al = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    assign is_dg = (b >= "0" && b <= "9");
    assign is_sp = (b == " ") || (b >= 8'd9 && b <= 8'd13);
    assign is_id = is_al || is_dg || (b == "_");
    assign col   = (r_col < LineTop) ? r_col + 1'b1 : LineTop;

    always_comb begin
        logic [4:0]      fk, sk;
        logic            fl, start, acc;
        logic [3:0]      cand;
        logic [2:0]      p;
        logic [TokW-1:0] ft;
        n_mode = r_mode; n_cand = r_cand; n_cnt = r_cnt; n_ovf = r_ovf;
        n_soff = r_soff; n_sline = r_sline; n_scol = r_scol;
        n_line = r_line; n_col = r_col; n_off = r_off;
        t0 = '0; t1 = '0; nt = 2'd0;
        fl = 1'b0; start = 1'b0; acc = 1'b0;
        // Pending token as it would be flushed now.
        case (r_mode)
            stt_pkg::M_IDENT: begin
                fk = stt_pkg::K_IDENT;
                if (r_cand[0] && r_cnt == CntBits'(3)) fk = stt_pkg::K_VAR;
                if (r_cand[1] && r_cnt == CntBits'(2)) fk = stt_pkg::K_IF;
                if (r_cand[2] && r_cnt == CntBits'(5)) fk = stt_pkg::K_PRINT;
                if (r_cand[3] && r_cnt == CntBits'(5)) fk = stt_pkg::K_PARSE;
            end
            stt_pkg::M_NUMBER: fk = stt_pkg::K_NUMBER;
            stt_pkg::M_STRING: fk = stt_pkg::K_STRING;
            default:           fk = stt_pkg::K_ASSIGN;
        endcase
        if (r_mode == stt_pkg::M_EQ) begin
            ft = mk(fk, r_sline, r_scol, r_soff, CntBits'(1), 1'b0);
        end else begin
            ft = mk(fk, r_sline, r_scol, r_soff, r_cnt, r_ovf);
        end
        cand = r_cand;
        sk = stt_pkg::single_kind(b);
        p = (r_cnt < CntBits'(5)) ? 3'(r_cnt) : 3'd7;

        if (i_q_item.eoi) begin
            if (r_mode != stt_pkg::M_HALT) begin
                if (r_mode != stt_pkg::M_IDLE) begin
                    t0 = ft;
                    t1 = mk(stt_pkg::K_END, r_line, col, r_off, '0, 1'b0);
                    nt = 2'd2;
                end else begin
                    t0 = mk(stt_pkg::K_END, r_line, col, r_off, '0, 1'b0);
                    nt = 2'd1;
                end
            end
            n_mode = stt_pkg::M_IDLE; n_cand = '1; n_cnt = '0; n_ovf = 1'b0;
            n_soff = '0; n_sline = LINE_BITS'(1); n_scol = '0;
            n_line = LINE_BITS'(1); n_col = '0; n_off = '0;
        end else if (r_mode != stt_pkg::M_HALT) begin
            case (r_mode)
                stt_pkg::M_IDENT:  if (is_id) acc = 1'b1; else begin fl = 1'b1; start = 1'b1; end
                stt_pkg::M_NUMBER: if (is_dg) acc = 1'b1; else begin fl = 1'b1; start = 1'b1; end
                stt_pkg::M_EQ: begin
                    if (b == "=") begin
                        t0 = mk(stt_pkg::K_EQEQ, r_sline, r_scol, r_soff,
                                CntBits'(2), 1'b0);
                        nt = 2'd1;
                        n_mode = stt_pkg::M_IDLE;
                    end else begin
                        fl = 1'b1; start = 1'b1;
                    end
                end
                stt_pkg::M_STRING: begin
                    if (b == "\"") begin
                        fl = 1'b1;
                    end else if (b == 8'd0) begin
                        fl = 1'b1; start = 1'b1;
                    end else begin
                        acc = 1'b1;
                    end
                end
                default: start = 1'b1;
            endcase
            if (fl) begin
                t0 = ft;
                nt = 2'd1;
                n_mode = stt_pkg::M_IDLE;
            end
            if (start && !is_sp) begin
                if (is_id || b == "\"" || b == "=") begin
                    n_mode = is_dg ? stt_pkg::M_NUMBER :
                             (b == "\"") ? stt_pkg::M_STRING :
                             (b == "=") ? stt_pkg::M_EQ : stt_pkg::M_IDENT;
                    n_sline = r_line; n_scol = col; n_soff = r_off;
                    n_cnt = '0; n_ovf = 1'b0; n_cand = '1;
                    if (is_id) begin
                        for (int w = 0; w < 4; w++) begin
                            if (stt_pkg::kw_char(2'(w), 3'd0) != b) n_cand[w] = 1'b0;
                        end
                        n_cnt = CntBits'(1);
                    end
                end else begin
                    if (b == 8'd0) begin
                        t1 = mk(stt_pkg::K_END, r_line, col, r_off, '0, 1'b0);
                        n_mode = stt_pkg::M_HALT;
                    end else if (sk != stt_pkg::K_END) begin
                        t1 = mk(sk, r_line, col, r_off, CntBits'(1), 1'b0);
                    end else begin
                        t1 = mk(stt_pkg::K_ERROR, r_line, col, r_off, CntBits'(1), 1'b0);
                        n_mode = stt_pkg::M_HALT;
                    end
                    if (fl) begin
                        nt = 2'd2;
                    end else begin
                        t0 = t1; nt = 2'd1;
                    end
                end
            end
            if (acc) begin
                for (int w = 0; w < 4; w++) begin
                    if (r_cand[w] && (r_cnt >= CntBits'(stt_pkg::kw_len(2'(w))) ||
                        stt_pkg::kw_char(2'(w), p) != b)) cand[w] = 1'b0;
                end
                n_cand = cand;
                if (r_cnt < CntMax) n_cnt = r_cnt + 1'b1;
                else n_ovf = 1'b1;
            end
            n_off = (r_off < OffTop) ? r_off + 1'b1 : OffTop;
            if (b == 8'h0A) begin
                if (r_line < LineTop) n_line = r_line + 1'b1;
                n_col = '0;
            end else begin
                n_col = col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= stt_pkg::M_IDLE;
            r_cand  <= '1;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_soff  <= '0;
            r_sline <= LINE_BITS'(1);
            r_scol  <= '0;
            r_line  <= LINE_BITS'(1);
            r_col   <= '0;
            r_off   <= '0;
            r_n     <= 2'd0;
        end else begin
            if (o_q_take) begin
                r_mode  <= n_mode;
                r_cand  <= n_cand;
                r_cnt   <= n_cnt;
                r_ovf   <= n_ovf;
                r_soff  <= n_soff;
                r_sline <= n_sline;
                r_scol  <= n_scol;
                r_line  <= n_line;
                r_col   <= n_col;
                r_off   <= n_off;
                r_n     <= nt;
            end else if (pop) begin
                r_n <= r_n - 2'd1;
            end
        end
        if (o_q_take) begin
            r_tok[0]  <= t0;
            r_tok[1]  <= t1;
            r_last[0] <= (nt == 2'd1);
            r_last[1] <= 1'b1;
        end else if (pop) begin
            r_tok[0]  <= r_tok[1];
            r_last[0] <= r_last[1];
        end
    end
endmodule
`default_nettype wire

// ===== sv/source_text_tokenizer.sv =====
`default_nettype none
// Source text tokenizer.
// Input channel: one beat per source byte (i_kind = 0, byte on i_data_byte)
// or an end marker (i_kind = 1). Output channel: one beat per token with
// kind, line, column, start offset, lexeme length, truncation flag, and
// o_last_of_run set on the last token caused by one input beat.
// A byte enters a two-entry queue; the token builder takes one queued beat
// per cycle when its output slots empty, and loads them with up to two tokens.
// Throughput is one byte per cycle while each byte yields at most one token and
// the receiver does not stall; a byte that yields two tokens holds off the next
// byte until its second token is taken. An accepted byte is registered in the
// queue, then its first token is registered in the output slots for taking.
// A token is emitted when the byte that ends it arrives; the end marker
// flushes the pending token and adds an end token, unless the stream halted.
// Synchronous reset empties the queue and output slots and returns line,
// column and offset counters to the start of a stream.
// When the receiver stalls, the shown token holds; the builder then stops
// and the queue fills, after which o_stall is raised toward the sender.
module source_text_tokenizer #(
    parameter int MAX_LEXEME  = stt_pkg::MaxLexeme,
    parameter int LINE_BITS   = stt_pkg::LineBits,
    parameter int OFFSET_BITS = stt_pkg::OffsetBits
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_kind,
    input  wire [7:0]   i_data_byte,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [4:0]  o_token_kind,
    output logic [15:0] o_token_line,
    output logic [15:0] o_token_column,
    output logic [19:0] o_start_offset,
    output logic [7:0]  o_lexeme_length,
    output logic        o_truncated,
    output logic        o_last_of_run
);
    logic           q_valid, q_take;
    stt_pkg::t_item q_item;

    stt_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_kind, .i_data_byte,
        .o_q_valid(q_valid), .o_q_item(q_item), .i_q_take(q_take)
    );

    stt_back #(
        .MAX_LEXEME(MAX_LEXEME), .LINE_BITS(LINE_BITS), .OFFSET_BITS(OFFSET_BITS)
    ) u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(q_valid), .i_q_item(q_item), .o_q_take(q_take),
        .o_valid, .i_stall, .o_token_kind, .o_token_line, .o_token_column,
        .o_start_offset, .o_lexeme_length, .o_truncated, .o_last_of_run
    );
endmodule
`default_nettype wire
